>>> hw/rtl/owrs_pkg.sv
// package for the 1-wire rom search decision core
// opcodes, result status codes, search commands and rom geometry
// no dependencies
`default_nettype none

package owrs_pkg;

    // input opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_BIT   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_CMD   = 3'd0;
    localparam logic [2:0] ST_DIR   = 3'd1;
    localparam logic [2:0] ST_FOUND = 3'd2;
    localparam logic [2:0] ST_FAIL  = 3'd3;
    localparam logic [2:0] ST_IDLE  = 3'd4;

    // search commands
    localparam logic [7:0] CMD_NORMAL = 8'hF0;
    localparam logic [7:0] CMD_COND   = 8'hEC;

    // rom geometry
    localparam int unsigned RomBits = 64;
    localparam logic [6:0] LAST_POS     = 7'd64;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0] COUNT_MAX    = 8'd255;

    typedef logic [RomBits-1:0] rom_t;

endpackage

`default_nettype wire

>>> hw/rtl/one_wire_rom_search.sv
// 1-wire rom search decision core, top level
// holds the search state and a registered result stage
// depends on owrs_pkg
//
// usage: each input transfer carries one opcode. clear wipes the search
// state, start follows a bus reset and returns the search command byte
// (or a failure), bit pair carries the two bits read from the bus and
// returns the direction bit to write (or a failure); the 64th bit reports the rom code.
// every input transfer produces exactly one result transfer.
// latency: the result is valid the cycle after the input transfer.
// throughput: one item per cycle while the result register is drained; the search
// state is updated in the same cycle the item is taken, so the next item may follow directly.
// stall: the result register holds its item while out_ready is low;
// in_ready is high whenever the result register is empty or being
// drained in the same cycle.
// reset: rst_n clears all search state, bit position goes to one, and
// the result register is empty.
`default_nettype none

module one_wire_rom_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic        presence,
    input  wire logic        normal_mode,
    input  wire logic        id_bit,
    input  wire logic        complement_bit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       command_byte,
    output logic             direction,
    output owrs_pkg::rom_t   rom_code,
    output logic [7:0]       found_count,
    output logic             last_device
);
    import owrs_pkg::*;

    // search state
    rom_t       rom_bits_reg,      rom_bits_next;
    logic [6:0] last_disc_reg,     last_disc_next;
    logic [3:0] last_fam_disc_reg, last_fam_disc_next;
    logic       last_dev_reg,      last_dev_next;
    logic [6:0] bit_pos_reg,       bit_pos_next;
    logic [6:0] last_zero_reg,     last_zero_next;
    logic       pass_active_reg,   pass_active_next;
    logic [7:0] total_reg,         total_next;

    // result stage
    logic       out_valid_reg;
    logic [2:0] status_reg,  status_next;
    logic [7:0] cmd_reg,     cmd_next;
    logic       dir_reg,     dir_next;
    rom_t       code_reg,    code_next;
    logic [7:0] count_reg;
    logic       last_reg;

    logic       accept;
    logic [6:0] pos;
    logic [5:0] idx;
    logic       dir;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // current bit position, out of range maps to one
    assign pos = (bit_pos_reg == 7'd0 || bit_pos_reg > LAST_POS) ? 7'd1 : bit_pos_reg;
    assign idx = 6'(pos - 7'd1);

    // direction choice for a discrepancy or a single reading
    always_comb
    begin
        if (id_bit != complement_bit)
        begin
            dir = id_bit;
        end
        else if (pos < last_disc_reg)
        begin
            dir = rom_bits_reg[idx];
        end
        else
        begin
            dir = (pos == last_disc_reg);
        end
    end

    // next state and result for one item
    always_comb
    begin
        rom_bits_next      = rom_bits_reg;
        last_disc_next     = last_disc_reg;
        last_fam_disc_next = last_fam_disc_reg;
        last_dev_next      = last_dev_reg;
        bit_pos_next       = bit_pos_reg;
        last_zero_next     = last_zero_reg;
        pass_active_next   = pass_active_reg;
        total_next         = total_reg;
        status_next        = ST_IDLE;
        cmd_next           = 8'd0;
        dir_next           = 1'b0;
        code_next          = '0;
        case (opcode)
            OP_CLEAR:
            begin
                rom_bits_next      = '0;
                last_disc_next     = 7'd0;
                last_fam_disc_next = 4'd0;
                last_dev_next      = 1'b0;
                bit_pos_next       = 7'd1;
                last_zero_next     = 7'd0;
                pass_active_next   = 1'b0;
                total_next         = 8'd0;
            end
            OP_START:
            begin
                if (!presence || last_dev_reg)
                begin
                    last_disc_next     = 7'd0;
                    last_fam_disc_next = 4'd0;
                    last_dev_next      = 1'b0;
                    total_next         = 8'd0;
                    pass_active_next   = 1'b0;
                    status_next        = ST_FAIL;
                end
                else
                begin
                    pass_active_next = 1'b1;
                    bit_pos_next     = 7'd1;
                    last_zero_next   = 7'd0;
                    cmd_next         = normal_mode ? CMD_NORMAL : CMD_COND;
                    status_next      = ST_CMD;
                end
            end
            OP_BIT:
            begin
                if (pass_active_reg)
                begin
                    if (id_bit && complement_bit)
                    begin
                        last_disc_next     = 7'd0;
                        last_fam_disc_next = 4'd0;
                        last_dev_next      = 1'b0;
                        total_next         = 8'd0;
                        pass_active_next   = 1'b0;
                        status_next        = ST_FAIL;
                    end
                    else
                    begin
                        dir_next = dir;
                        // zero taken at a discrepancy
                        if (id_bit == complement_bit && !dir)
                        begin
                            last_zero_next = pos;
                            if (pos < FAMILY_LIMIT)
                            begin
                                last_fam_disc_next = pos[3:0];
                            end
                        end
                        rom_bits_next[idx] = dir;
                        if (pos >= LAST_POS)
                        begin
                            // end of pass
                            pass_active_next = 1'b0;
                            bit_pos_next     = 7'd1;
                            last_disc_next   = last_zero_next;
                            if (last_zero_next == 7'd0)
                            begin
                                last_dev_next = 1'b1;
                            end
                            if (rom_bits_next[7:0] == 8'd0)
                            begin
                                last_disc_next     = 7'd0;
                                last_fam_disc_next = 4'd0;
                                last_dev_next      = 1'b0;
                                total_next         = 8'd0;
                                status_next        = ST_FAIL;
                            end
                            else
                            begin
                                if (total_reg != COUNT_MAX)
                                begin
                                    total_next = total_reg + 8'd1;
                                end
                                code_next   = rom_bits_next;
                                status_next = ST_FOUND;
                            end
                        end
                        else
                        begin
                            bit_pos_next = pos + 7'd1;
                            status_next  = ST_DIR;
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_IDLE;
            end
        endcase
    end

    // search state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bits_reg      <= '0;
            last_disc_reg     <= 7'd0;
            last_fam_disc_reg <= 4'd0;
            last_dev_reg      <= 1'b0;
            bit_pos_reg       <= 7'd1;
            last_zero_reg     <= 7'd0;
            pass_active_reg   <= 1'b0;
            total_reg         <= 8'd0;
        end
        else if (accept)
        begin
            rom_bits_reg      <= rom_bits_next;
            last_disc_reg     <= last_disc_next;
            last_fam_disc_reg <= last_fam_disc_next;
            last_dev_reg      <= last_dev_next;
            bit_pos_reg       <= bit_pos_next;
            last_zero_reg     <= last_zero_next;
            pass_active_reg   <= pass_active_next;
            total_reg         <= total_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            cmd_reg    <= cmd_next;
            dir_reg    <= dir_next;
            code_reg   <= code_next;
            count_reg  <= total_next;
            last_reg   <= last_dev_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign command_byte = cmd_reg;
    assign direction    = dir_reg;
    assign rom_code     = code_reg;
    assign found_count  = count_reg;
    assign last_device  = last_reg;

    // a reported code never has a zero family byte
    a_found_family: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FOUND) |-> (code_reg[7:0] != 8'd0))
        else $error("found code with zero family byte");

    // rom code is only shown with a found device
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_FOUND) |-> (code_reg == '0))
        else $error("rom code shown without a found device");

    // a command result carries one of the two search commands
    a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_CMD) |->
        (cmd_reg == CMD_NORMAL || cmd_reg == CMD_COND))
        else $error("bad search command byte");

    // an active pass stays within the 64 rom bits
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pass_active_reg |-> (bit_pos_reg != 7'd0 && bit_pos_reg <= LAST_POS))
        else $error("bit position out of range during a pass");

    // no pass may run once the last device was found
    a_last_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
        pass_active_reg |-> !last_dev_reg)
        else $error("pass active after last device");

endmodule

`default_nettype wire

>>> dv/one_wire_rom_search_tb.sv
// testbench for the 1-wire rom search decision core: a bus of simulated devices
// feeds bit pairs, a predictor tracks the search state and checks every result
// depends on owrs_pkg and one_wire_rom_search
`timescale 1ns / 100ps

module one_wire_rom_search_tb;

    import owrs_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned REPORT_CAP = 200;

    typedef struct packed {
        logic [1:0] op;
        logic       presence;
        logic       normal;
        logic       id;
        logic       cmp;
    } search_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] command;
        logic       direction;
        rom_t       code;
        logic [7:0] count;
        logic       last;
    } search_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_PULSED
    } ready_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = OP_CLEAR;
    logic       presence = 1'b0;
    logic       normal_mode = 1'b0;
    logic       id_bit = 1'b0;
    logic       complement_bit = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [7:0] command_byte;
    logic       direction;
    rom_t       rom_code;
    logic [7:0] found_count;
    logic       last_device;

    one_wire_rom_search dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .presence       (presence),
        .normal_mode    (normal_mode),
        .id_bit         (id_bit),
        .complement_bit (complement_bit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .command_byte   (command_byte),
        .direction      (direction),
        .rom_code       (rom_code),
        .found_count    (found_count),
        .last_device    (last_device)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    search_item_t   queued_items[$];
    search_result_t predicted_results[$];
    rom_t           bus_codes[$];

    // search state mirror
    rom_t       path_bits;
    logic [6:0] disc_pos;
    logic [3:0] family_disc;
    logic       last_seen;
    logic [6:0] bit_pos;
    logic [6:0] zero_pos;
    logic       pass_on;
    logic [7:0] dev_total;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_span = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    search_item_t   next_item;
    search_result_t want;

    // full clear of the mirrored search state
    function automatic void search_clear();
        path_bits = '0;
        disc_pos = '0;
        family_disc = '0;
        last_seen = 1'b0;
        bit_pos = 7'd1;
        zero_pos = '0;
        pass_on = 1'b0;
        dev_total = '0;
    endfunction

    // failed pass, code bits are kept
    function automatic void abort_search();
        disc_pos = '0;
        family_disc = '0;
        last_seen = 1'b0;
        dev_total = '0;
        pass_on = 1'b0;
    endfunction

    // one decision of the search, updates the mirrored state
    function automatic search_result_t search_step(search_item_t it);
        search_result_t r;
        logic [6:0]     pos;
        int             idx;
        r = '0;
        r.status = ST_IDLE;
        case (it.op)
            OP_CLEAR: search_clear();
            OP_START:
            begin
                if (!it.presence || last_seen)
                begin
                    abort_search();
                    r.status = ST_FAIL;
                end
                else
                begin
                    pass_on = 1'b1;
                    bit_pos = 7'd1;
                    zero_pos = '0;
                    r.command = it.normal ? CMD_NORMAL : CMD_COND;
                    r.status = ST_CMD;
                end
            end
            OP_BIT:
            begin
                if (pass_on && it.id && it.cmp)
                begin
                    abort_search();
                    r.status = ST_FAIL;
                end
                else if (pass_on)
                begin
                    pos = bit_pos;
                    idx = int'(pos) - 1;
                    // all devices agree: follow the bus, else pick the branch
                    if (it.id != it.cmp)
                        r.direction = it.id;
                    else
                    begin
                        if (pos < disc_pos)
                            r.direction = path_bits[idx];
                        else
                            r.direction = (pos == disc_pos);
                        if (!r.direction)
                        begin
                            zero_pos = pos;
                            if (pos < FAMILY_LIMIT)
                                family_disc = pos[3:0];
                        end
                    end
                    path_bits[idx] = r.direction;
                    // last slot closes the pass
                    if (pos >= LAST_POS)
                    begin
                        pass_on = 1'b0;
                        bit_pos = 7'd1;
                        disc_pos = zero_pos;
                        if (disc_pos == '0)
                            last_seen = 1'b1;
                        if (path_bits[7:0] == 8'd0)
                        begin
                            abort_search();
                            r.status = ST_FAIL;
                        end
                        else
                        begin
                            if (dev_total != COUNT_MAX)
                                dev_total = dev_total + 8'd1;
                            r.code = path_bits;
                            r.status = ST_FOUND;
                        end
                    end
                    else
                    begin
                        bit_pos = pos + 7'd1;
                        r.status = ST_DIR;
                    end
                end
            end
            default: ;
        endcase
        r.count = dev_total;
        r.last = last_seen;
        return r;
    endfunction

    function automatic rom_t rand_code();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_item(logic [1:0] op, logic pres, logic norm, logic idb,
                                      logic cmpb);
        search_item_t it;
        it.op = op;
        it.presence = pres;
        it.normal = norm;
        it.id = idb;
        it.cmp = cmpb;
        queued_items.push_back(it);
    endfunction

    // any opcode, any fields
    function automatic void push_noise();
        push_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
    endfunction

    function automatic void push_start(logic pres);
        push_item(OP_START, pres, 1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // search order: lower bit index first, zero branch before one
    function automatic bit precedes(rom_t a, rom_t b);
        rom_t diff;
        diff = a ^ b;
        return (diff != '0) && ((a & (diff & (~diff + 1'b1))) == '0);
    endfunction

    // keep the bus sorted in the order the search finds devices
    function automatic void add_device(rom_t code);
        int i;
        i = 0;
        while (i < bus_codes.size() && precedes(bus_codes[i], code))
            i++;
        if (i < bus_codes.size() && bus_codes[i] == code)
            return;
        bus_codes.insert(i, code);
    endfunction

    // related codes so that branches split at many depths
    function automatic void build_bus(int count, bit zero_family);
        rom_t base;
        rom_t code;
        bus_codes.delete();
        base = rand_code();
        while (bus_codes.size() < count)
        begin
            code = base ^ (rand_code() & rand_code() & rand_code());
            if (code[7:0] == 8'd0)
                code[0] = 1'b1;
            add_device(code);
        end
        if (zero_family)
        begin
            code = rand_code();
            code[7:0] = 8'd0;
            add_device(code);
        end
    endfunction

    // 64 bit pairs as the wired-and bus answers while walking toward target
    function automatic bit run_pass(rom_t target, int noise_div);
        bit   disturbed;
        logic idb;
        logic cmpb;
        rom_t low_mask;
        disturbed = 1'b0;
        for (int b = 0; b < RomBits; b++)
        begin
            low_mask = (rom_t'(1) << b) - 1'b1;
            idb = 1'b1;
            cmpb = 1'b1;
            foreach (bus_codes[d])
                if (((bus_codes[d] ^ target) & low_mask) == '0)
                begin
                    idb &= bus_codes[d][b];
                    cmpb &= ~bus_codes[d][b];
                end
            if (noise_div != 0 && $urandom_range(1, noise_div) == 1)
            begin
                disturbed = 1'b1;
                if ($urandom_range(0, 1) == 0)
                    push_noise();
                else
                begin
                    idb = 1'($urandom);
                    cmpb = 1'($urandom);
                end
            end
            push_item(OP_BIT, 1'($urandom), 1'($urandom), idb, cmpb);
        end
        return disturbed;
    endfunction

    task automatic check_field(input string field, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            if (fail_count < REPORT_CAP)
                $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int idx;
        int passes;
        int bus_num;
        bit disturbed;

        // directed: ignored items, failures, both commands, restarts, clears
        push_item(OP_BIT, 1'b1, 1'b1, 1'b1, 1'b0);
        push_item(OP_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1);
        push_item(OP_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(OP_START, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(OP_START, 1'b1, 1'b1, 1'b1, 1'b1);
        push_item(OP_BIT, 1'b0, 1'b0, 1'b1, 1'b0);
        push_item(OP_BIT, 1'b1, 1'b1, 1'b0, 1'b1);
        push_item(OP_BIT, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(OP_START, 1'b1, 1'b0, 1'b0, 1'b1);
        push_item(OP_BIT, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(OP_BIT, 1'b0, 1'b0, 1'b1, 1'b1);
        push_item(OP_BIT, 1'b0, 1'b1, 1'b0, 1'b1);
        push_item(OP_START, 1'b1, 1'b0, 1'b1, 1'b0);
        push_item(OP_BIT, 1'b1, 1'b1, 1'b1, 1'b0);
        push_item(OP_CLEAR, 1'b1, 1'b1, 1'b1, 1'b1);
        push_item(OP_BIT, 1'b0, 1'b0, 1'b0, 1'b1);
        push_item(OP_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0);

        // lone device with an all-ones code, then one with a zero family byte
        bus_codes = '{'1};
        push_start(1'b1);
        void'(run_pass(bus_codes[0], 0));
        push_start(1'b1);
        bus_codes = '{64'hFFFF_FFFF_FFFF_FF00};
        push_start(1'b1);
        void'(run_pass(bus_codes[0], 0));

        // random buses, mostly clean passes with some noise and broken passes
        bus_num = 0;
        while (queued_items.size() < RANDOM_ITEMS)
        begin
            build_bus($urandom_range(1, 4), (bus_num % 3 == 2) || ($urandom_range(0, 7) == 0));
            bus_num++;
            if ($urandom_range(0, 1) == 0)
                push_item(OP_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            idx = 0;
            passes = bus_codes.size() + $urandom_range(1, 2);
            repeat (passes)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_noise();
                if (idx >= bus_codes.size())
                begin
                    // last device already found: this start fails
                    push_start(1'b1);
                    idx = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    push_start(1'b0);
                    idx = 0;
                end
                else
                begin
                    push_start(1'b1);
                    disturbed = run_pass(bus_codes[idx], ($urandom_range(0, 2) == 0) ? 40 : 0);
                    if (disturbed || bus_codes[idx][7:0] == 8'd0)
                        idx = 0;
                    else
                        idx++;
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_items.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0 && predicted_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // input driver: bursts with random gaps, prediction on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_CLEAR;
            presence <= 1'b0;
            normal_mode <= 1'b0;
            id_bit <= 1'b0;
            complement_bit <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            search_clear();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                next_item.op = opcode;
                next_item.presence = presence;
                next_item.normal = normal_mode;
                next_item.id = id_bit;
                next_item.cmp = complement_bit;
                predicted_results.push_back(search_step(next_item));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_items.size() != 0)
                begin
                    next_item = queued_items.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_item.op;
                    presence <= next_item.presence;
                    normal_mode <= next_item.normal;
                    id_bit <= next_item.id;
                    complement_bit <= next_item.cmp;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        // long stretch with no idling
                        burst_left = $urandom_range(50, 200);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                   $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (ready_span == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_span = $urandom_range(20, 200);
            end
            else
                ready_span--;
            case (ready_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_COIN:   out_ready <= 1'($urandom);
                READY_MOSTLY: out_ready <= ($urandom_range(0, 5) != 0);
                default:      out_ready <= (cycle_count[2:0] != 3'd0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result transfer with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("command_byte", 64'(want.command), 64'(command_byte));
                check_field("direction", 64'(want.direction), 64'(direction));
                check_field("rom_code", want.code, rom_code);
                check_field("found_count", 64'(want.count), 64'(found_count));
                check_field("last_device", 64'(want.last), 64'(last_device));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
